// ===== rtl/aum_pkg.sv =====
package aum_pkg;

  localparam int unsigned AGENTS_DEF  = 64;
  localparam int unsigned STATES_DEF  = 2;
  localparam int unsigned HISTORY_DEF = 60;

  // agent counters wide enough for 256 and for first + count
  localparam int unsigned AG_CNT_W = 9;
  localparam int unsigned PCT_W    = 15;
  localparam int unsigned PADDR_W  = 3;
  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
  localparam logic [6:0] ACTIVE_RST = 7'd64;

  // register index as seen in paddr[2]
  localparam logic REG_ACTIVE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_SNAP   = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    AGGR_ONE = 2'd0,
    AGGR_AVG = 2'd1,
    AGGR_MAX = 2'd2,
    AGGR_MIN = 2'd3
  } aggr_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SNP_RD,
    ST_SNP_WR,
    ST_QRY_NEW,
    ST_QRY_OLD,
    ST_QRY_ACC,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] now_ticks;
    logic [5:0]  agent;
    logic [6:0]  agent_count;
    logic        state_sel;
    aggr_e       aggr_mode;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent_q8;
    logic             window_valid;
  } out_item_t;

endpackage

// ===== rtl/aum_if.sv =====
interface aum_in_if;
  logic               valid;
  logic               ready;
  aum_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aum_out_if;
  logic               valid;
  logic               ready;
  aum_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/agent_utilization_monitor_top.sv =====
// Per-agent state time accounting with a snapshot history ring. Items are taken one at a
// time: a state change reads and rewrites its agent's row, a snapshot reads each active
// agent's row and writes it into the ring, and a query reads the newest and oldest ring
// entry per agent in its range, then does one multiply, a saturation check and a 16-step
// restoring divide. The agent table and the ring each sit in a memory with a synchronous
// read port and a write port. A result waits in an output register, so a new item
// is taken while it is unclaimed. A valid flag per agent saves a clearing pass at reset.
module agent_utilization_monitor_top #(
  parameter int unsigned AGENTS  = aum_pkg::AGENTS_DEF,
  parameter int unsigned STATES  = aum_pkg::STATES_DEF,
  parameter int unsigned HISTORY = aum_pkg::HISTORY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  aum_in_if.sink                       in_i,
  aum_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aum_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned AI_W   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
  localparam int unsigned CW     = aum_pkg::AG_CNT_W;
  localparam int unsigned SL_W   = $clog2(HISTORY);
  localparam int unsigned FL_W   = $clog2(HISTORY + 1);
  localparam int unsigned HA_W   = $clog2(AGENTS * HISTORY);
  localparam int unsigned HR_W   = STATES * 16;
  localparam int unsigned ROW_W  = 1 + 32 + HR_W;
  localparam int unsigned ACC_W  = 16 + $clog2(AGENTS);
  localparam int unsigned PROD_W = ACC_W + aum_pkg::PCT_W;
  localparam int unsigned PW     = aum_pkg::PCT_W;

  aum_pkg::fsm_e state_q, state_d;

  // configuration
  logic [6:0] active_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[aum_pkg::PADDR_W-1] == aum_pkg::REG_ACTIVE) ? {25'd0, active_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= aum_pkg::ACTIVE_RST;
    end else if (cfg_wr && paddr[aum_pkg::PADDR_W-1] == aum_pkg::REG_ACTIVE) begin
      active_q <= pwdata[6:0];
    end
  end

  // memories
  logic [ROW_W-1:0] agent_mem [AGENTS];
  logic [HR_W-1:0]  hist_mem [AGENTS*HISTORY];
  logic [AGENTS-1:0] row_vld_q;
  logic             rd_vld_q;
  logic [ROW_W-1:0] ag_rdata_q, ag_wdata;
  logic [AI_W-1:0]  ag_raddr, ag_waddr;
  logic             ag_we;
  logic [HR_W-1:0]  hist_rdata_q;
  logic [HA_W-1:0]  hist_raddr, hist_waddr;
  logic             hist_we;

  // agent row update
  logic [ROW_W-1:0] row;
  logic [HR_W-1:0]  row_ticks, ticks_upd;
  logic [31:0]      row_last;
  logic             row_cur, elapsed_ok;
  logic [15:0]      elapsed;

  always_ff @(posedge clk_i) begin
    if (ag_we) begin
      agent_mem[ag_waddr] <= ag_wdata;
    end
    ag_rdata_q <= agent_mem[ag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= ticks_upd;
    end
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  // item and walk registers
  aum_pkg::in_item_t item_q;
  logic [CW-1:0]     a_q, end_q, walk_d, end_d, end_sum;
  logic [HA_W-1:0]   hbase_q;
  logic [SL_W-1:0]   oldest_q, slot_q, newest_q;
  logic [FL_W-1:0]   filled_q;
  logic [FL_W:0]     slot_sum, new_sum;
  logic [HR_W-1:0]   new_q;
  logic [ACC_W-1:0]  counter_q, total_q;
  logic              picked_q;
  logic [PROD_W-1:0] rem_q;
  logic [PROD_W-1:0] dsr_q;
  logic [3:0]        bit_q;
  logic [15:0]       quo_q, quo_next;
  logic [PW-1:0]     pct_q;
  logic              div_ge, sat;
  logic              out_valid_q;
  aum_pkg::out_item_t out_q;
  logic              in_acc, out_free, done_go;

  assign in_i.ready  = (state_q == aum_pkg::ST_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_free    = ~out_valid_q | out_o.ready;
  assign done_go     = (state_q == aum_pkg::ST_DONE) & out_free;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ring positions seen by a new item
  assign slot_sum = (FL_W+1)'(oldest_q) + (FL_W+1)'(filled_q);
  assign new_sum  = slot_sum - (FL_W+1)'(1);
  assign walk_d   = (CW'(active_q) > CW'(AGENTS)) ? CW'(AGENTS) : CW'(active_q);
  assign end_sum  = (in_i.data.aggr_mode == aum_pkg::AGGR_ONE)
                    ? CW'(in_i.data.agent) + CW'(1)
                    : CW'(in_i.data.agent) + CW'(in_i.data.agent_count);
  assign end_d    = (end_sum > CW'(AGENTS)) ? CW'(AGENTS) : end_sum;

  assign row        = rd_vld_q ? ag_rdata_q : '0;
  assign row_ticks  = row[HR_W-1:0];
  assign row_last   = row[HR_W +: 32];
  assign row_cur    = row[ROW_W-1];
  assign elapsed_ok = item_q.now_ticks > row_last;
  assign elapsed    = item_q.now_ticks[15:0] - row_last[15:0];

  always_comb begin
    for (int s = 0; s < STATES; s++) begin
      ticks_upd[s*16 +: 16] = row_ticks[s*16 +: 16] +
                              ((elapsed_ok && s == int'(row_cur)) ? elapsed : 16'd0);
    end
  end

  // per-agent window difference
  logic [15:0] agent_total, one_ctr, diff;
  logic        take;

  always_comb begin
    agent_total = '0;
    one_ctr     = '0;
    diff        = '0;
    for (int s = 0; s < STATES; s++) begin
      diff        = new_q[s*16 +: 16] - hist_rdata_q[s*16 +: 16];
      agent_total = agent_total + diff;
      if (s == int'(item_q.state_sel)) begin
        one_ctr = diff;
      end
    end
  end

  always_comb begin
    if (item_q.aggr_mode == aum_pkg::AGGR_MAX) begin
      take = !picked_q || (ACC_W'(one_ctr) > counter_q);
    end else begin
      take = !picked_q || (ACC_W'(one_ctr) < counter_q);
    end
  end

  assign div_ge   = rem_q >= dsr_q;
  assign quo_next = quo_q | (div_ge ? (16'd1 << bit_q) : 16'd0);
  assign sat      = {1'b0, rem_q} >= {total_q, 16'd0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aum_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_i.data.func)
            aum_pkg::FUNC_UPDATE: begin
              state_d = (CW'(in_i.data.agent) < CW'(AGENTS)) ? aum_pkg::ST_UPD_RD
                                                             : aum_pkg::ST_DONE;
            end
            aum_pkg::FUNC_SNAP: begin
              state_d = (walk_d == '0) ? aum_pkg::ST_DONE : aum_pkg::ST_SNP_RD;
            end
            aum_pkg::FUNC_QUERY: begin
              state_d = (filled_q >= FL_W'(2) && CW'(in_i.data.agent) < end_d)
                        ? aum_pkg::ST_QRY_NEW : aum_pkg::ST_DONE;
            end
            default: state_d = aum_pkg::ST_DONE;
          endcase
        end
      end
      aum_pkg::ST_UPD_RD:  state_d = aum_pkg::ST_UPD_WR;
      aum_pkg::ST_UPD_WR:  state_d = aum_pkg::ST_DONE;
      aum_pkg::ST_SNP_RD:  state_d = aum_pkg::ST_SNP_WR;
      aum_pkg::ST_SNP_WR: begin
        state_d = (a_q + CW'(1) == walk_d) ? aum_pkg::ST_DONE : aum_pkg::ST_SNP_RD;
      end
      aum_pkg::ST_QRY_NEW: state_d = aum_pkg::ST_QRY_OLD;
      aum_pkg::ST_QRY_OLD: state_d = aum_pkg::ST_QRY_ACC;
      aum_pkg::ST_QRY_ACC: begin
        state_d = (a_q + CW'(1) >= end_q) ? aum_pkg::ST_MUL : aum_pkg::ST_QRY_NEW;
      end
      aum_pkg::ST_MUL:     state_d = aum_pkg::ST_CHK;
      aum_pkg::ST_CHK: begin
        state_d = (total_q == '0 || sat) ? aum_pkg::ST_DONE : aum_pkg::ST_DIV;
      end
      aum_pkg::ST_DIV: begin
        state_d = (bit_q == 4'd0) ? aum_pkg::ST_DONE : aum_pkg::ST_DIV;
      end
      aum_pkg::ST_DONE: begin
        state_d = out_free ? aum_pkg::ST_IDLE : aum_pkg::ST_DONE;
      end
      default: state_d = aum_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ag_raddr   = a_q[AI_W-1:0];
    ag_waddr   = AI_W'(item_q.agent);
    ag_we      = 1'b0;
    ag_wdata   = {item_q.state_sel, item_q.now_ticks, ticks_upd};
    hist_we    = 1'b0;
    hist_waddr = hbase_q + HA_W'(slot_q);
    hist_raddr = hbase_q + HA_W'(newest_q);
    case (state_q)
      aum_pkg::ST_UPD_RD:  ag_raddr = AI_W'(item_q.agent);
      aum_pkg::ST_UPD_WR:  ag_we = 1'b1;
      aum_pkg::ST_SNP_WR:  hist_we = 1'b1;
      aum_pkg::ST_QRY_OLD: hist_raddr = hbase_q + HA_W'(oldest_q);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aum_pkg::ST_IDLE;
      filled_q    <= '0;
      oldest_q    <= '0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= row_vld_q[ag_raddr];
      if (ag_we) begin
        row_vld_q[ag_waddr] <= 1'b1;
      end
      if (in_acc && in_i.data.func == aum_pkg::FUNC_SNAP) begin
        if (filled_q < FL_W'(HISTORY)) begin
          filled_q <= filled_q + FL_W'(1);
        end else if (oldest_q == SL_W'(HISTORY - 1)) begin
          oldest_q <= '0;
        end else begin
          oldest_q <= oldest_q + SL_W'(1);
        end
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      aum_pkg::ST_IDLE: begin
        item_q    <= in_i.data;
        pct_q     <= '0;
        counter_q <= '0;
        total_q   <= '0;
        picked_q  <= 1'b0;
        end_q     <= end_d;
        slot_q    <= (slot_sum >= (FL_W+1)'(HISTORY)) ? SL_W'(slot_sum - (FL_W+1)'(HISTORY))
                                                     : SL_W'(slot_sum);
        newest_q  <= (new_sum >= (FL_W+1)'(HISTORY)) ? SL_W'(new_sum - (FL_W+1)'(HISTORY))
                                                    : SL_W'(new_sum);
        if (in_i.data.func == aum_pkg::FUNC_QUERY) begin
          a_q     <= CW'(in_i.data.agent);
          hbase_q <= HA_W'(in_i.data.agent) * HA_W'(HISTORY);
        end else begin
          a_q     <= '0;
          hbase_q <= '0;
        end
      end
      aum_pkg::ST_SNP_WR: begin
        a_q     <= a_q + CW'(1);
        hbase_q <= hbase_q + HA_W'(HISTORY);
      end
      aum_pkg::ST_QRY_OLD: begin
        new_q <= hist_rdata_q;
      end
      aum_pkg::ST_QRY_ACC: begin
        a_q      <= a_q + CW'(1);
        hbase_q  <= hbase_q + HA_W'(HISTORY);
        picked_q <= 1'b1;
        if (item_q.aggr_mode == aum_pkg::AGGR_ONE || item_q.aggr_mode == aum_pkg::AGGR_AVG) begin
          counter_q <= counter_q + ACC_W'(one_ctr);
          total_q   <= total_q + ACC_W'(agent_total);
        end else if (take) begin
          counter_q <= ACC_W'(one_ctr);
          total_q   <= ACC_W'(agent_total);
        end
      end
      aum_pkg::ST_MUL: begin
        rem_q <= PROD_W'(counter_q) * PROD_W'(aum_pkg::PCT_FULL);
        dsr_q <= {total_q, 15'd0};
        bit_q <= 4'd15;
        quo_q <= '0;
      end
      aum_pkg::ST_CHK: begin
        if (total_q != '0 && sat) begin
          pct_q <= aum_pkg::PCT_FULL;
        end
      end
      aum_pkg::ST_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dsr_q;
        end
        dsr_q <= dsr_q >> 1;
        quo_q <= quo_next;
        bit_q <= bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          pct_q <= (quo_next > 16'(aum_pkg::PCT_FULL)) ? aum_pkg::PCT_FULL : PW'(quo_next);
        end
      end
      default: ;
    endcase
    if (done_go) begin
      out_q.percent_q8   <= pct_q;
      out_q.window_valid <= filled_q >= FL_W'(2);
    end
  end

endmodule

// ===== rtl/aum_checker.sv =====
module aum_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [14:0] out_pct_i,
  input logic        out_window_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pct_i) && $stable(out_window_i))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after an accepted item");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_pct_i <= 15'd25600)
    else $error("percentage above full scale");

  a_no_window_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_window_i |-> out_pct_i == 15'd0)
    else $error("nonzero percentage without a valid window");

endmodule

bind agent_utilization_monitor_top aum_port_checker u_aum_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_pct_i    (out_o.data.percent_q8),
  .out_window_i (out_o.data.window_valid)
);

// ===== dv/aum_checker.sv =====
`timescale 1ns / 1ps

module aum_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  aum_in_if                           in_ch,
  aum_out_if                          out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [aum_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors_o,
  output int                          pending_o,
  output int                          checked_o
);

  localparam int NAG = aum_pkg::AGENTS_DEF;
  localparam int NST = aum_pkg::STATES_DEF;
  localparam int NHI = aum_pkg::HISTORY_DEF;

  logic [6:0]  active_q;
  logic [15:0] tick_cnt [NAG][NST];
  logic [31:0] last_tick [NAG];
  logic        cur_state [NAG];
  logic [15:0] ring [NAG][NST][NHI];
  int          ring_old;
  int          ring_fill;
  aum_pkg::out_item_t expected_q [$];

  function automatic logic [aum_pkg::PCT_W-1:0] query_share(aum_pkg::in_item_t it);
    int          newest;
    int          stop;
    logic [31:0] total;
    logic [31:0] counter;
    logic [15:0] one_tot;
    logic [15:0] one_cnt;
    bit          picked;
    logic [63:0] q;
    total = 0;
    counter = 0;
    picked = 0;
    if (ring_fill < 2) return '0;
    newest = (ring_old + ring_fill - 1) % NHI;
    stop = (it.aggr_mode == aum_pkg::AGGR_ONE) ? int'(it.agent) + 1
                                               : int'(it.agent) + int'(it.agent_count);
    if (stop > NAG) stop = NAG;
    for (int a = it.agent; a < stop; a++) begin
      one_tot = '0;
      for (int s = 0; s < NST; s++) one_tot += ring[a][s][newest] - ring[a][s][ring_old];
      one_cnt = ring[a][it.state_sel][newest] - ring[a][it.state_sel][ring_old];
      if (it.aggr_mode == aum_pkg::AGGR_ONE || it.aggr_mode == aum_pkg::AGGR_AVG) begin
        total += one_tot;
        counter += one_cnt;
      end else if (!picked || (it.aggr_mode == aum_pkg::AGGR_MAX ? one_cnt > counter
                                                                 : one_cnt < counter)) begin
        counter = one_cnt;
        total = one_tot;
      end
      picked = 1;
    end
    if (total == 0) return '0;
    q = (64'(counter) * 64'(aum_pkg::PCT_FULL)) / 64'(total);
    return (q > 64'(aum_pkg::PCT_FULL)) ? aum_pkg::PCT_FULL : q[aum_pkg::PCT_W-1:0];
  endfunction

  task automatic apply_item(aum_pkg::in_item_t it);
    aum_pkg::out_item_t exp_item;
    int        slot;
    int        walk;
    exp_item = '0;
    case (it.func)
      aum_pkg::FUNC_UPDATE: begin
        if (it.now_ticks > last_tick[it.agent])
          tick_cnt[it.agent][cur_state[it.agent]] += 16'(it.now_ticks - last_tick[it.agent]);
        last_tick[it.agent] = it.now_ticks;
        cur_state[it.agent] = it.state_sel;
      end
      aum_pkg::FUNC_SNAP: begin
        slot = (ring_old + ring_fill) % NHI;
        walk = (active_q > NAG) ? NAG : int'(active_q);
        if (ring_fill < NHI) ring_fill++;
        else ring_old = (ring_old + 1) % NHI;
        for (int a = 0; a < walk; a++) begin
          for (int s = 0; s < NST; s++) ring[a][s][slot] = tick_cnt[a][s];
          if (it.now_ticks > last_tick[a])
            ring[a][cur_state[a]][slot] += 16'(it.now_ticks - last_tick[a]);
        end
      end
      aum_pkg::FUNC_QUERY: exp_item.percent_q8 = query_share(it);
      default: ;
    endcase
    exp_item.window_valid = (ring_fill >= 2);
    expected_q.push_back(exp_item);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    aum_pkg::out_item_t want;
    if (!rst_ni) begin
      active_q <= aum_pkg::ACTIVE_RST;
      ring_old = 0;
      ring_fill = 0;
      for (int a = 0; a < NAG; a++) begin
        last_tick[a] = '0;
        cur_state[a] = 1'b0;
        for (int s = 0; s < NST; s++) tick_cnt[a][s] = '0;
      end
      expected_q.delete();
      errors_o <= 0;
      checked_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == aum_pkg::REG_ACTIVE)
        active_q <= pwdata[6:0];
      if (in_ch.valid && in_ch.ready) apply_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected result %p", out_ch.data);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.data.percent_q8 !== want.percent_q8 ||
              out_ch.data.window_valid !== want.window_valid) begin
            if (errors_o < 10)
              $display("ERROR: pct exp %0d got %0d, window exp %0b got %0b",
                       want.percent_q8, out_ch.data.percent_q8,
                       want.window_valid, out_ch.data.window_valid);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== dv/agent_utilization_monitor_top_tb.sv =====
`timescale 1ns / 1ps

module agent_utilization_monitor_top_tb;

  localparam int LIMIT = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [aum_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  int                 checked;
  int                 cycles = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 sent = 0;

  // stimulus-side view of the ring, to keep queries on written entries
  int          walk_of [aum_pkg::HISTORY_DEF];
  int          trk_old = 0;
  int          trk_fill = 0;
  int          cur_active = 64;
  logic [31:0] tnow = 0;

  aum_in_if  in_ch ();
  aum_out_if out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  agent_utilization_monitor_top dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  aum_checker chk (
    .clk_i, .rst_ni, .in_ch, .out_ch, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata, .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("agent_utilization_monitor_top regression: fail");
      $finish;
    end
  end

  task automatic write_active(int val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_active = val;
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  function automatic int query_span();
    int n;
    int o;
    if (trk_fill < 2) return 64;
    n = (trk_old + trk_fill - 1) % aum_pkg::HISTORY_DEF;
    o = walk_of[trk_old];
    return (walk_of[n] < o) ? walk_of[n] : o;
  endfunction

  task automatic send(aum_pkg::in_item_t it);
    if (it.func == aum_pkg::FUNC_SNAP) begin
      walk_of[(trk_old + trk_fill) % aum_pkg::HISTORY_DEF] = (cur_active > 64) ? 64
                                                                               : cur_active;
      if (trk_fill < aum_pkg::HISTORY_DEF) trk_fill++;
      else trk_old = (trk_old + 1) % aum_pkg::HISTORY_DEF;
    end
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic aum_pkg::in_item_t mk(aum_pkg::func_e f, logic [31:0] t, int ag,
                                           int cnt, bit st, aum_pkg::aggr_e m);
    aum_pkg::in_item_t it;
    it.func = f;
    it.now_ticks = t;
    it.agent = 6'(ag);
    it.agent_count = 7'(cnt);
    it.state_sel = st;
    it.aggr_mode = m;
    return it;
  endfunction

  function automatic aum_pkg::in_item_t rand_item();
    int r;
    int lim;
    int ag;
    r = $urandom_range(99);
    tnow += ($urandom_range(19) == 0) ? $urandom_range(70000) : $urandom_range(1, 3000);
    if (r >= 62 && r < 92) begin
      lim = query_span();
      if (lim > 0) begin
        ag = $urandom_range(lim - 1);
        return mk(aum_pkg::FUNC_QUERY, $urandom, ag,
                  (lim == 64) ? $urandom_range(127) : $urandom_range(lim - ag),
                  $urandom_range(1), aum_pkg::aggr_e'($urandom_range(3)));
      end
    end
    if (r < 45 || (r >= 62 && r < 92))
      return mk(aum_pkg::FUNC_UPDATE, tnow, $urandom_range(63), $urandom_range(127),
                $urandom_range(1), aum_pkg::aggr_e'($urandom_range(3)));
    if (r < 62) return mk(aum_pkg::FUNC_SNAP, tnow, $urandom_range(63), $urandom_range(127),
                          $urandom_range(1), aum_pkg::aggr_e'($urandom_range(3)));
    // noise: stale or wild times and the unused function
    return mk((r < 95) ? aum_pkg::FUNC_UPDATE : (r < 97) ? aum_pkg::FUNC_SNAP
                                                         : aum_pkg::FUNC_NONE, $urandom,
              $urandom_range(63), $urandom_range(127), $urandom_range(1),
              aum_pkg::aggr_e'($urandom_range(3)));
  endfunction

  initial begin
    int actives [6] = '{1, 0, 127, 37, 64, 64};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_active(64);

    // directed: empty window, time extremes, all modes, range cut-off
    send(mk(aum_pkg::FUNC_QUERY, 0, 0, 1, 0, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_UPDATE, 0, 0, 1, 1, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 63, 127, 1, aum_pkg::AGGR_MIN));
    send(mk(aum_pkg::FUNC_UPDATE, 100, 1, 1, 1, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_SNAP, 150, 0, 1, 0, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_QUERY, 0, 1, 64, 1, aum_pkg::AGGR_AVG));
    send(mk(aum_pkg::FUNC_UPDATE, 90, 1, 1, 0, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_UPDATE, 70000, 2, 1, 1, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_UPDATE, 400, 1, 1, 1, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_SNAP, 90000, 0, 1, 0, aum_pkg::AGGR_ONE));
    for (int m = 0; m < 4; m++) begin
      send(mk(aum_pkg::FUNC_QUERY, 0, 0, 64, 0, aum_pkg::aggr_e'(m)));
      send(mk(aum_pkg::FUNC_QUERY, 0, 1, 3, 1, aum_pkg::aggr_e'(m)));
    end
    send(mk(aum_pkg::FUNC_QUERY, 0, 63, 127, 0, aum_pkg::AGGR_AVG));
    send(mk(aum_pkg::FUNC_QUERY, 0, 2, 0, 1, aum_pkg::AGGR_MAX));
    send(mk(aum_pkg::FUNC_QUERY, 0, 2, 1, 1, aum_pkg::AGGR_ONE));
    send(mk(aum_pkg::FUNC_NONE, 32'hFFFF_FFFF, 63, 127, 1, aum_pkg::AGGR_MIN));
    tnow = 100_000;

    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 140; k++) begin
        case ((k / 35 + ph) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 86; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 86; end
          default: begin idle_pct = 30; stall_pct = 30; end
        endcase
        send(rand_item());
      end
      drain();
      write_active(actives[ph]);
    end
    drain();

    $display("sent %0d items over six active_agents settings (0, 1, 37, 64, 127)", sent);
    $display("checked %0d results under mixed sender gaps and receiver stalls", checked);
    if (errors == 0 && pending == 0) begin
      $display("agent_utilization_monitor_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("agent_utilization_monitor_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aum_pkg.sv
rtl/aum_if.sv
rtl/agent_utilization_monitor_top.sv
rtl/aum_checker.sv
dv/aum_checker.sv
dv/agent_utilization_monitor_top_tb.sv
